@@ hdl/assert_macros.svh @@
// Assertion macros used by the filter's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcaf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcaf assertion failed");

`endif

@@ hdl/rcaf_pkg.sv @@
// Shared types, constants and microcode table of the resonant cascade filter.
`default_nettype none

package rcaf_pkg;

    localparam int ST_W    = 32;              // stage state width
    localparam int ACC_W   = 38;              // feedback target width
    localparam int MB_W    = 21;              // coefficient operand width
    localparam int PROD_W  = ACC_W + MB_W;    // product width
    localparam int SUM_W   = 40;              // update adder width
    localparam int FRAC_W  = 16;              // coefficient fraction bits
    localparam int STEP_W  = 4;
    localparam int MODE_W  = 2;
    localparam int CUT_W   = 16;
    localparam int FB_W    = 20;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HP = 2'd1;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_POLES,
        REG_CUTOFF,
        REG_FEEDBACK
    } reg_idx_t;

    typedef enum logic [1:0] {
        A_D12,
        A_ACC,
        A_D23,
        A_D34
    } a_sel_t;

    typedef enum logic {
        B_FB,
        B_CUT
    } b_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_X,
        WR_ACC,
        WR_S1,
        WR_S2,
        WR_S3,
        WR_S4,
        WR_OUT
    } wr_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_TWO_POLE,
        JMP_WAIT_OUT,
        JMP_GOTO
    } jmp_t;

    typedef struct packed {
        logic   mul_en;
        a_sel_t a_sel;
        b_sel_t b_sel;
        wr_t    wr;
        jmp_t   jmp;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic four_pole;
        logic out_free;
    } stat_t;

    // Microcode addresses.
    localparam step_t ST_IDLE   = 4'd0;
    localparam step_t ST_FB_MUL = 4'd1;
    localparam step_t ST_TARGET = 4'd2;
    localparam step_t ST_S1_MUL = 4'd3;
    localparam step_t ST_S1_UPD = 4'd4;
    localparam step_t ST_S2_MUL = 4'd5;
    localparam step_t ST_S2_UPD = 4'd6;
    localparam step_t ST_S3_MUL = 4'd7;
    localparam step_t ST_S3_UPD = 4'd8;
    localparam step_t ST_S4_MUL = 4'd9;
    localparam step_t ST_S4_UPD = 4'd10;
    localparam step_t ST_OUT    = 4'd11;

    function automatic ctrl_t mk(input logic mul_en, input a_sel_t a_sel, input b_sel_t b_sel,
                                 input wr_t wr, input jmp_t jmp, input step_t target);
        ctrl_t w;
        w.mul_en = mul_en;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.wr     = wr;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    // The program: one control word per step.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        unique case (step)
            ST_IDLE:   w = mk(1'b0, A_D12, B_FB,  WR_X,    JMP_WAIT_IN,  ST_IDLE);
            ST_FB_MUL: w = mk(1'b1, A_D12, B_FB,  WR_NONE, JMP_NEXT,     ST_IDLE);
            ST_TARGET: w = mk(1'b0, A_D12, B_FB,  WR_ACC,  JMP_NEXT,     ST_IDLE);
            ST_S1_MUL: w = mk(1'b1, A_ACC, B_CUT, WR_NONE, JMP_NEXT,     ST_IDLE);
            ST_S1_UPD: w = mk(1'b0, A_D12, B_CUT, WR_S1,   JMP_NEXT,     ST_IDLE);
            ST_S2_MUL: w = mk(1'b1, A_D12, B_CUT, WR_NONE, JMP_NEXT,     ST_IDLE);
            ST_S2_UPD: w = mk(1'b0, A_D12, B_CUT, WR_S2,   JMP_TWO_POLE, ST_OUT);
            ST_S3_MUL: w = mk(1'b1, A_D23, B_CUT, WR_NONE, JMP_NEXT,     ST_IDLE);
            ST_S3_UPD: w = mk(1'b0, A_D23, B_CUT, WR_S3,   JMP_NEXT,     ST_IDLE);
            ST_S4_MUL: w = mk(1'b1, A_D34, B_CUT, WR_NONE, JMP_NEXT,     ST_IDLE);
            ST_S4_UPD: w = mk(1'b0, A_D34, B_CUT, WR_S4,   JMP_NEXT,     ST_IDLE);
            ST_OUT:    w = mk(1'b0, A_D12, B_CUT, WR_OUT,  JMP_WAIT_OUT, ST_IDLE);
            default:   w = mk(1'b0, A_D12, B_CUT, WR_NONE, JMP_GOTO,     ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rcaf_sequencer.sv @@
// Step counter and microcode lookup with conditional jumps.
`default_nettype none

module rcaf_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire rcaf_pkg::stat_t stat,
    output rcaf_pkg::ctrl_t     ctrl,
    output logic                in_stall
);
    import rcaf_pkg::*;

    step_t step_reg;
    step_t step_next;
    ctrl_t rom_word;

    assign rom_word = ucode(step_reg);
    assign in_stall = (rom_word.jmp != JMP_WAIT_IN);

    // Waiting steps hold their write until their condition is met.
    always_comb
    begin
        ctrl      = rom_word;
        step_next = step_reg + 1'b1;
        unique case (rom_word.jmp)
            JMP_NEXT:
            begin
                step_next = step_reg + 1'b1;
            end
            JMP_WAIT_IN:
            begin
                if (!in_valid)
                begin
                    step_next = step_reg;
                    ctrl.wr   = WR_NONE;
                end
            end
            JMP_TWO_POLE:
            begin
                if (!stat.four_pole)
                begin
                    step_next = rom_word.target;
                end
            end
            JMP_WAIT_OUT:
            begin
                if (stat.out_free)
                begin
                    step_next = rom_word.target;
                end
                else
                begin
                    step_next = step_reg;
                    ctrl.wr   = WR_NONE;
                end
            end
            JMP_GOTO:
            begin
                step_next = rom_word.target;
            end
            default:
            begin
                step_next = ST_IDLE;
                ctrl.wr   = WR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rcaf_datapath.sv @@
// Stage registers, shared multiplier, saturating update adder and output register.
`default_nettype none

module rcaf_datapath #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rcaf_pkg::ctrl_t               ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic [rcaf_pkg::MODE_W-1:0]   filter_mode,
    input  wire logic                          four_pole,
    input  wire logic [rcaf_pkg::CUT_W-1:0]    cutoff_coeff,
    input  wire logic [rcaf_pkg::FB_W-1:0]     feedback_gain,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output rcaf_pkg::stat_t                    stat
);
    import rcaf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [ST_W-1:0]        s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_next;

    logic signed [ST_W:0]    d12, d23, d34;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [SUM_W-1:0] shf, base, sum;
    logic signed [ST_W-1:0]  sat_st;
    logic signed [ST_W:0]    y;

    assign d12 = {s1_reg[ST_W-1], s1_reg} - {s2_reg[ST_W-1], s2_reg};
    assign d23 = {s2_reg[ST_W-1], s2_reg} - {s3_reg[ST_W-1], s3_reg};
    assign d34 = {s3_reg[ST_W-1], s3_reg} - {s4_reg[ST_W-1], s4_reg};

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_D12:   mul_a = ACC_W'(d12);
            A_ACC:   mul_a = acc_reg;
            A_D23:   mul_a = ACC_W'(d23);
            A_D34:   mul_a = ACC_W'(d34);
            default: mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_FB:    mul_b = {1'b0, feedback_gain};
            B_CUT:   mul_b = {{(MB_W - CUT_W){1'b0}}, cutoff_coeff};
            default: mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Floor shift of the product; the shifted value always fits the adder width.
    assign shf = $signed(prod_reg[FRAC_W+SUM_W-1:FRAC_W]);

    always_comb
    begin
        unique case (ctrl.wr)
            WR_ACC:  base = SUM_W'(x_reg) - SUM_W'(s1_reg);
            WR_S1:   base = SUM_W'(s1_reg);
            WR_S2:   base = SUM_W'(s2_reg);
            WR_S3:   base = SUM_W'(s3_reg);
            WR_S4:   base = SUM_W'(s4_reg);
            default: base = '0;
        endcase
    end

    assign sum = base + shf;

    always_comb
    begin
        if ((&sum[SUM_W-1:ST_W-1]) || !(|sum[SUM_W-1:ST_W-1]))
        begin
            sat_st = sum[ST_W-1:0];
        end
        else
        begin
            sat_st = sum[SUM_W-1] ? {1'b1, {(ST_W - 1){1'b0}}} : {1'b0, {(ST_W - 1){1'b1}}};
        end
    end

    always_comb
    begin
        if (filter_mode == MODE_LP)
        begin
            y = four_pole ? (ST_W + 1)'(s4_reg) : (ST_W + 1)'(s2_reg);
        end
        else if (filter_mode == MODE_HP)
        begin
            y = (ST_W + 1)'(x_reg) - (four_pole ? (ST_W + 1)'(s4_reg) : (ST_W + 1)'(s1_reg));
        end
        else
        begin
            y = '0;
        end
        if ((&y[ST_W:SAMPLE_BITS-1]) || !(|y[ST_W:SAMPLE_BITS-1]))
        begin
            out_data_next = y[SAMPLE_BITS-1:0];
        end
        else
        begin
            out_data_next = y[ST_W] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            s4_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr == WR_S1)
            begin
                s1_reg <= sat_st;
            end
            if (ctrl.wr == WR_S2)
            begin
                s2_reg <= sat_st;
            end
            if (ctrl.wr == WR_S3)
            begin
                s3_reg <= sat_st;
            end
            if (ctrl.wr == WR_S4)
            begin
                s4_reg <= sat_st;
            end
            if (ctrl.wr == WR_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr == WR_X)
        begin
            x_reg <= sample_in;
        end
        if (ctrl.wr == WR_ACC)
        begin
            acc_reg <= sum[ACC_W-1:0];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.wr == WR_OUT)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_out     = out_data_reg;
    assign stat.four_pole = four_pole;
    assign stat.out_free  = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

@@ hdl/resonant_cascade_audio_filter_unit.sv @@
// Top level of the resonant one-pole cascade audio filter.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   sample_in (signed, SAMPLE_BITS)
//   output    out        out_valid / out_stall sample_out (signed, SAMPLE_BITS)
//   config    in         APB write/read        filter_mode, four_pole, cutoff, feedback
//
// Each sample is worked by the microcode program, which runs every product
// through one shared multiplier with a register after it; in two-pole
// operation the program skips the third and fourth stage updates.
// Reset clears the stage states, the step counter, the output valid flag and
// the configuration registers to their documented values.
// A stalled output beat holds the program on its final step; the next input
// beat is taken as soon as the result has been loaded into the output register.
`default_nettype none

`include "assert_macros.svh"

module resonant_cascade_audio_filter_unit #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input channel.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    // Output channel.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rcaf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rcaf_pkg::DATA_W-1:0]   pwdata,
    output logic [rcaf_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import rcaf_pkg::*;

    logic [MODE_W-1:0] filter_mode_reg;
    logic              four_pole_reg;
    logic [CUT_W-1:0]  cutoff_coeff_reg;
    logic [FB_W-1:0]   feedback_gain_reg;

    reg_idx_t reg_idx;
    logic     cfg_write;
    ctrl_t    ctrl;
    stat_t    stat;

    // Registers sit at word addresses; the low two address bits are ignored.
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg   <= MODE_LP;
            four_pole_reg     <= 1'b0;
            cutoff_coeff_reg  <= 16'h8000;
            feedback_gain_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MODE:     filter_mode_reg   <= pwdata[MODE_W-1:0];
                REG_POLES:    four_pole_reg     <= pwdata[0];
                REG_CUTOFF:   cutoff_coeff_reg  <= pwdata[CUT_W-1:0];
                REG_FEEDBACK: feedback_gain_reg <= pwdata[FB_W-1:0];
                default:      filter_mode_reg   <= filter_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:     prdata = DATA_W'(filter_mode_reg);
            REG_POLES:    prdata = DATA_W'(four_pole_reg);
            REG_CUTOFF:   prdata = DATA_W'(cutoff_coeff_reg);
            REG_FEEDBACK: prdata = DATA_W'(feedback_gain_reg);
            default:      prdata = '0;
        endcase
    end

    // The sequencer steps through the program and gates the datapath writes.
    rcaf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_stall (in_stall)
    );

    // The datapath holds the four stages and the registered output beat.
    rcaf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .sample_in     (sample_in),
        .filter_mode   (filter_mode_reg),
        .four_pole     (four_pole_reg),
        .cutoff_coeff  (cutoff_coeff_reg),
        .feedback_gain (feedback_gain_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .sample_out    (sample_out),
        .stat          (stat)
    );

    // An accepted beat puts the block to work for the following cycles.
    `RCAF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // Loading a result presents it and returns the program to the idle step.
    `RCAF_ASSERT_NEXT(a_result_after_load, clk, rst_n, ctrl.wr == WR_OUT, out_valid && !in_stall)
    // The sample register is loaded only on an accepted input beat.
    `RCAF_ASSERT_SAME(a_load_on_accept, clk, rst_n, ctrl.wr == WR_X, in_valid && !in_stall)

endmodule

`default_nettype wire
